// ----- hw/rtl/order_crossover_child_top_assert.svh -----
// Assertion macros for the order crossover child block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef ORDER_CROSSOVER_CHILD_TOP_ASSERT_SVH
`define ORDER_CROSSOVER_CHILD_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define OCX_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define OCX_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ocx_pkg.sv -----
// Shared constants and helpers for the order crossover child block.
// No dependencies.
package ocx_pkg;

    localparam int GENE_W = 7;
    localparam int CUT_W  = 7;
    localparam int CFG_W  = 7;
    localparam int WORD_W = GENE_W + 1;

    localparam logic [CFG_W-1:0] CITY_COUNT_RESET = 7'd64;

    function automatic logic gene_ok(input logic [GENE_W-1:0] g,
                                     input logic [GENE_W-1:0] max_g);
        return (g != '0) && (g <= max_g);
    endfunction

endpackage

// ----- hw/rtl/ocx_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
// Depends on nothing.
module ocx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/ocx_store.sv -----
// Two-bank parent gene stores, one write port and one registered read per store.
// Depends on ocx_pkg.
module ocx_store #(
    parameter int MAX_GENES = 64
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(MAX_GENES):0] wr_addr,
    input  logic [ocx_pkg::GENE_W-1:0] wr_p1,
    input  logic [ocx_pkg::GENE_W-1:0] wr_p2,
    input  logic [$clog2(MAX_GENES):0] rd1_addr,
    input  logic [$clog2(MAX_GENES):0] rd2_addr,
    output logic [ocx_pkg::GENE_W-1:0] p1_rd,
    output logic [ocx_pkg::GENE_W-1:0] p2_rd
);

    localparam int DEPTH = 2 * (2 ** $clog2(MAX_GENES));

    logic [ocx_pkg::GENE_W-1:0] p1_mem [DEPTH];
    logic [ocx_pkg::GENE_W-1:0] p2_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            p1_mem[wr_addr] <= wr_p1;
        end
        p1_rd <= p1_mem[rd1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            p2_mem[wr_addr] <= wr_p2;
        end
        p2_rd <= p2_mem[rd2_addr];
    end

endmodule

// ----- hw/rtl/ocx_front.sv -----
// Front end: takes parent words, writes the stores, builds the used mask
// and queues one job per pair. Depends on ocx_pkg.
module ocx_front #(
    parameter int MAX_GENES = 64,
    parameter int AW        = $clog2(MAX_GENES),
    parameter int CW        = $clog2(MAX_GENES + 1),
    parameter int JW        = 1 + 3 * CW + MAX_GENES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ocx_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [ocx_pkg::GENE_W-1:0] first_parent_gene,
    input  logic [ocx_pkg::GENE_W-1:0] second_parent_gene,
    input  logic [ocx_pkg::CUT_W-1:0]  cut_start,
    input  logic [ocx_pkg::CUT_W-1:0]  cut_end,
    input  logic                       is_final,
    input  logic                       job_full,
    output logic                       job_push,
    output logic [JW-1:0]              job_data,
    output logic                       wr_en,
    output logic [AW:0]                wr_addr,
    output logic [ocx_pkg::GENE_W-1:0] wr_p1,
    output logic [ocx_pkg::GENE_W-1:0] wr_p2
);

    logic [ocx_pkg::CFG_W-1:0] city_count_reg;
    logic [AW-1:0]             load_pos_reg;
    logic [AW-1:0]             load_pos_next;
    logic [ocx_pkg::CUT_W-1:0] seg_low_reg;
    logic [ocx_pkg::CUT_W-1:0] seg_high_reg;
    logic [MAX_GENES-1:0]      mask_reg;
    logic [MAX_GENES-1:0]      mask_next;
    logic                      bank_reg;

    logic                      accept;
    logic [CW-1:0]             limit;
    logic [AW-1:0]             pos;
    logic                      first_pos;
    logic [ocx_pkg::CUT_W-1:0] seg_lo;
    logic [ocx_pkg::CUT_W-1:0] seg_hi;
    logic                      in_seg;
    logic [MAX_GENES-1:0]      mask_upd;
    logic [CW-1:0]             n;
    logic                      done;
    logic [CW-1:0]             lo_clamp;
    logic [CW-1:0]             hi_clamp;

    assign cfg_ready = 1'b1;
    assign full      = job_full;
    assign accept    = push && !full;

    always_comb
    begin
        if (city_count_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (city_count_reg > ocx_pkg::CFG_W'(MAX_GENES))
        begin
            limit = CW'(MAX_GENES);
        end
        else
        begin
            limit = CW'(city_count_reg);
        end
    end

    always_comb
    begin
        if (CW'(load_pos_reg) >= limit)
        begin
            pos = AW'(limit - CW'(1));
        end
        else
        begin
            pos = load_pos_reg;
        end
    end

    assign first_pos = (pos == '0);
    assign seg_lo = !first_pos ? seg_low_reg :
                    ((cut_start <= cut_end) ? cut_start : cut_end);
    assign seg_hi = !first_pos ? seg_high_reg :
                    ((cut_start <= cut_end) ? cut_end : cut_start);
    assign in_seg = (ocx_pkg::CUT_W'(pos) >= seg_lo) && (ocx_pkg::CUT_W'(pos) < seg_hi);

    always_comb
    begin
        mask_upd = first_pos ? '0 : mask_reg;
        if (in_seg && ocx_pkg::gene_ok(first_parent_gene, ocx_pkg::GENE_W'(MAX_GENES)))
        begin
            mask_upd[AW'(first_parent_gene - ocx_pkg::GENE_W'(1))] = 1'b1;
        end
    end

    assign n        = CW'(pos) + CW'(1);
    assign done     = is_final || (n >= limit);
    assign lo_clamp = (seg_lo < ocx_pkg::CUT_W'(n)) ? CW'(seg_lo) : n;
    assign hi_clamp = (seg_hi < ocx_pkg::CUT_W'(n)) ? CW'(seg_hi) : n;

    assign job_push = accept && done;
    assign job_data = {bank_reg, n, lo_clamp, hi_clamp, mask_upd};

    assign wr_en   = accept;
    assign wr_addr = {bank_reg, pos};
    assign wr_p1   = first_parent_gene;
    assign wr_p2   = second_parent_gene;

    assign load_pos_next = done ? '0 : AW'(n);
    assign mask_next     = done ? '0 : mask_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= ocx_pkg::CITY_COUNT_RESET;
            load_pos_reg   <= '0;
            seg_low_reg    <= '0;
            seg_high_reg   <= '0;
            mask_reg       <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                city_count_reg <= cfg_data;
            end
            if (accept)
            begin
                load_pos_reg <= load_pos_next;
                seg_low_reg  <= seg_lo;
                seg_high_reg <= seg_hi;
                mask_reg     <= mask_next;
                if (done)
                begin
                    bank_reg <= !bank_reg;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/ocx_back.sv -----
// Back end: walks one queued job, reads the stores and emits child words.
// Depends on ocx_pkg.
module ocx_back #(
    parameter int MAX_GENES = 64,
    parameter int AW        = $clog2(MAX_GENES),
    parameter int CW        = $clog2(MAX_GENES + 1),
    parameter int JW        = 1 + 3 * CW + MAX_GENES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_empty,
    input  logic [JW-1:0]              job_data,
    output logic                       job_pop,
    output logic [AW:0]                rd1_addr,
    output logic [AW:0]                rd2_addr,
    input  logic [ocx_pkg::GENE_W-1:0] p1_rd,
    input  logic [ocx_pkg::GENE_W-1:0] p2_rd,
    input  logic                       out_full,
    output logic                       out_push,
    output logic [ocx_pkg::WORD_W-1:0] out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [AW-1:0]              k_reg;
    logic [AW-1:0]              k_next;
    logic [CW-1:0]              j_reg;
    logic [CW-1:0]              j_next;

    logic                       bank;
    logic [CW-1:0]              n;
    logic [CW-1:0]              lo;
    logic [CW-1:0]              hi;
    logic [MAX_GENES-1:0]       mask;
    logic                       in_seg;
    logic                       j_done;
    logic                       p2_used;
    logic                       is_last;
    logic                       emit_try;
    logic                       take_p2;
    logic [ocx_pkg::GENE_W-1:0] gene_sel;

    assign bank = job_data[JW-1];
    assign n    = job_data[JW-2 -: CW];
    assign lo   = job_data[JW-2-CW -: CW];
    assign hi   = job_data[JW-2-2*CW -: CW];
    assign mask = job_data[MAX_GENES-1:0];

    assign in_seg  = (CW'(k_reg) >= lo) && (CW'(k_reg) < hi);
    assign j_done  = (j_reg >= n);
    assign p2_used = ocx_pkg::gene_ok(p2_rd, ocx_pkg::GENE_W'(MAX_GENES))
                     && mask[AW'(p2_rd - ocx_pkg::GENE_W'(1))];
    assign is_last = (CW'(k_reg) == n - CW'(1));

    always_comb
    begin
        emit_try = 1'b1;
        take_p2  = 1'b0;
        gene_sel = '0;
        if (in_seg)
        begin
            gene_sel = p1_rd;
        end
        else if (j_done)
        begin
            gene_sel = '0;
        end
        else if (p2_used)
        begin
            emit_try = 1'b0;
        end
        else
        begin
            gene_sel = p2_rd;
            take_p2  = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        out_push   = 1'b0;
        job_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                j_next = '0;
                if (!job_empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!emit_try)
                begin
                    // skip a parent-two gene already in the segment
                    j_next = j_reg + CW'(1);
                end
                else if (!out_full)
                begin
                    out_push = 1'b1;
                    k_next   = k_reg + AW'(1);
                    if (take_p2)
                    begin
                        j_next = j_reg + CW'(1);
                    end
                    if (is_last)
                    begin
                        job_pop    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_data = {is_last, gene_sel};
    assign rd1_addr = {bank, k_next};
    assign rd2_addr = {bank, AW'(j_next)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

endmodule

// ----- hw/rtl/order_crossover_child_top.sv -----
// Order crossover child generator: top level.
// Depends on ocx_pkg, ocx_fifo, ocx_store, ocx_front, ocx_back.
//
// Input queue side: one word per parent position (push/full). The first word
// of a pair also carries the two cut points. A pair ends on is_final or when
// city_count words (clamped to 1..MAX_GENES) have been taken. The user must
// write city_count on the cfg channel (cfg_ready is always high) between
// pairs; the block itself does not enforce this.
// Result queue side (empty/pop): one word per child position, child_last on
// the final one. A waiting word holds until popped.
// Loading takes one parent word per cycle while full is low. A finished
// pair becomes a job in a two-entry queue; the back end passes its idle
// state, then emits child words while the result queue has room and skips
// parent-two genes in the segment (single read port on each parent store).
// The first child word waits on the job queue, idle state and store read.
// Parents sit in two banks, so one pair loads while the previous one emits;
// full rises when both banks hold unfinished pairs, which a stalled result
// side causes once the result queue is full and two pairs are queued.
// Reset: control clears, city_count returns to 64, both queues empty.
module order_crossover_child_top #(
    parameter int MAX_GENES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ocx_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [ocx_pkg::GENE_W-1:0] first_parent_gene,
    input  logic [ocx_pkg::GENE_W-1:0] second_parent_gene,
    input  logic [ocx_pkg::CUT_W-1:0]  cut_start,
    input  logic [ocx_pkg::CUT_W-1:0]  cut_end,
    input  logic                       is_final,
    output logic                       empty,
    input  logic                       pop,
    output logic [ocx_pkg::GENE_W-1:0] child_gene,
    output logic                       child_last
);

    localparam int AW = $clog2(MAX_GENES);
    localparam int CW = $clog2(MAX_GENES + 1);
    localparam int JW = 1 + 3 * CW + MAX_GENES;

    logic                       job_full;
    logic                       job_push;
    logic [JW-1:0]              job_wr;
    logic                       job_empty;
    logic                       job_pop;
    logic [JW-1:0]              job_rd;
    logic                       wr_en;
    logic [AW:0]                wr_addr;
    logic [ocx_pkg::GENE_W-1:0] wr_p1;
    logic [ocx_pkg::GENE_W-1:0] wr_p2;
    logic [AW:0]                rd1_addr;
    logic [AW:0]                rd2_addr;
    logic [ocx_pkg::GENE_W-1:0] p1_rd;
    logic [ocx_pkg::GENE_W-1:0] p2_rd;
    logic                       out_full;
    logic                       out_push;
    logic [ocx_pkg::WORD_W-1:0] out_wr;
    logic [ocx_pkg::WORD_W-1:0] out_rd;

    ocx_front #(
        .MAX_GENES (MAX_GENES),
        .AW        (AW),
        .CW        (CW),
        .JW        (JW)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .push               (push),
        .full               (full),
        .first_parent_gene  (first_parent_gene),
        .second_parent_gene (second_parent_gene),
        .cut_start          (cut_start),
        .cut_end            (cut_end),
        .is_final           (is_final),
        .job_full           (job_full),
        .job_push           (job_push),
        .job_data           (job_wr),
        .wr_en              (wr_en),
        .wr_addr            (wr_addr),
        .wr_p1              (wr_p1),
        .wr_p2              (wr_p2)
    );

    ocx_fifo #(
        .WIDTH (JW),
        .DEPTH (2)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .full    (job_full),
        .wr_data (job_wr),
        .pop     (job_pop),
        .empty   (job_empty),
        .rd_data (job_rd)
    );

    ocx_store #(
        .MAX_GENES (MAX_GENES)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_p1    (wr_p1),
        .wr_p2    (wr_p2),
        .rd1_addr (rd1_addr),
        .rd2_addr (rd2_addr),
        .p1_rd    (p1_rd),
        .p2_rd    (p2_rd)
    );

    ocx_back #(
        .MAX_GENES (MAX_GENES),
        .AW        (AW),
        .CW        (CW),
        .JW        (JW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_rd),
        .job_pop   (job_pop),
        .rd1_addr  (rd1_addr),
        .rd2_addr  (rd2_addr),
        .p1_rd     (p1_rd),
        .p2_rd     (p2_rd),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_wr)
    );

    ocx_fifo #(
        .WIDTH (ocx_pkg::WORD_W),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .full    (out_full),
        .wr_data (out_wr),
        .pop     (pop),
        .empty   (empty),
        .rd_data (out_rd)
    );

    assign child_last = out_rd[ocx_pkg::WORD_W-1];
    assign child_gene = out_rd[ocx_pkg::GENE_W-1:0];

endmodule

// ----- hw/rtl/ocx_checker.sv -----
// Port-level checks for order_crossover_child_top, with its bind.
// Depends on order_crossover_child_top_assert.svh.
`include "order_crossover_child_top_assert.svh"

module ocx_checker #(
    parameter int MAX_GENES = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [6:0] child_gene,
    input logic       child_last
);

    logic       seen_item_reg;
    logic [6:0] word_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_item_reg <= 1'b0;
            word_cnt_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                seen_item_reg <= 1'b1;
            end
            if (pop && !empty)
            begin
                word_cnt_reg <= child_last ? '0 : word_cnt_reg + 7'd1;
            end
        end
    end

    `OCX_CHECK_NEXT(a_hold_word, !empty && !pop, !empty, "waiting child word dropped")
    `OCX_CHECK_NEXT(a_hold_data, !empty && !pop, $stable(child_gene) && $stable(child_last), "waiting child word changed")
    `OCX_CHECK_NOW(a_no_early_out, !seen_item_reg, empty && !full, "queue state before any input")
    `OCX_CHECK_NOW(a_child_len, pop && !empty && !child_last, word_cnt_reg < 7'(MAX_GENES - 1), "child longer than tour limit")

endmodule

bind order_crossover_child_top ocx_checker #(
    .MAX_GENES (MAX_GENES)
) u_ocx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .child_gene (child_gene),
    .child_last (child_last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for order_crossover_child_top: directed parent pairs, then random pairs.
// Checks each child word against in-bench order crossover predictions or typed rows.
// Depends on ocx_pkg and the order_crossover_child_top RTL.
module testbench;

    localparam int GENE_W      = ocx_pkg::GENE_W;
    localparam int CUT_W       = ocx_pkg::CUT_W;
    localparam int CFG_W       = ocx_pkg::CFG_W;
    localparam int MAX_GENES   = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 58;
    localparam int BOTH_PCT    = 29;
    localparam int HOLD_CYCLES = 400;
    localparam int N_DIR       = 19;
    localparam int N_PHASES    = 8;
    localparam int PRESSURE_PH = 5;
    localparam int LONG_PH     = 3;
    localparam int PAUSE_PH    = 6;
    localparam int PHASE_ITEMS = 4;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [GENE_W-1:0] gene;
        logic              last;
    } child_word_t;

    typedef struct packed {
        logic [GENE_W-1:0] g1;
        logic [GENE_W-1:0] g2;
        logic [CUT_W-1:0]  ca;
        logic [CUT_W-1:0]  cb;
        logic              fin;
        logic [1:0]        n_typed;
        logic [GENE_W-1:0] e0;
        logic [GENE_W-1:0] e1;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{7'd1,  7'd2,   7'd0,   7'd1,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd1,   7'd2},
        '{7'd1,  7'd2,   7'd2,   7'd0,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd1,   7'd2},
        '{7'd1,  7'd2,   7'd1,   7'd1,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd2,   7'd1},
        '{7'd1,  7'd2,   7'd127, 7'd100, 1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd2,   7'd1},
        '{7'd0,  7'd2,   7'd0,   7'd1,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd0,   7'd2},
        '{7'd1,  7'd127, 7'd0,   7'd0,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd127, 7'd1},
        '{7'd1,  7'd1,   7'd0,   7'd1,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd1,   7'd0,   7'd0,   1'b1, 2'd2, 7'd1,   7'd0},
        '{7'd5,  7'd5,   7'd0,   7'd1,   1'b1, 2'd1, 7'd5,   7'd0},
        '{7'd64, 7'd3,   7'd1,   7'd3,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd2,  7'd64,  7'd0,   7'd0,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd3,  7'd2,   7'd0,   7'd0,   1'b0, 2'd0, 7'd0,   7'd0},
        '{7'd1,  7'd1,   7'd0,   7'd0,   1'b1, 2'd0, 7'd0,   7'd0}
    };

    localparam int PH_CFG [N_PHASES] = '{8, 2, 0, 127, 1, 64, 5, 64};
    localparam idle_mode_t PH_MODE [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                                  IDLE_SEND, IDLE_NONE, IDLE_BOTH, IDLE_RECV};

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              push;
    logic              full;
    logic [GENE_W-1:0] first_parent_gene;
    logic [GENE_W-1:0] second_parent_gene;
    logic [CUT_W-1:0]  cut_start;
    logic [CUT_W-1:0]  cut_end;
    logic              is_final;
    logic              empty;
    logic              pop;
    logic [GENE_W-1:0] child_gene;
    logic              child_last;

    child_word_t       child_q[$];
    child_word_t       seen_word;
    int                errors;
    int                cycle_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_left;
    bit                hold_req;
    bit                hold_seen;

    logic [GENE_W-1:0] p1_mem [MAX_GENES];
    logic [GENE_W-1:0] p2_mem [MAX_GENES];
    logic [63:0]       used_genes;
    int unsigned       load_cnt;
    int unsigned       seg_lo;
    int unsigned       seg_hi;
    logic [CFG_W-1:0]  city_cfg;

    order_crossover_child_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .first_parent_gene (first_parent_gene),
        .second_parent_gene(second_parent_gene),
        .cut_start         (cut_start),
        .cut_end           (cut_end),
        .is_final          (is_final),
        .empty             (empty),
        .pop               (pop),
        .child_gene        (child_gene),
        .child_last        (child_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic bit gene_valid(input logic [GENE_W-1:0] g);
        return g >= 1 && g <= MAX_GENES;
    endfunction

    function automatic int unsigned tour_limit();
        int unsigned lim;
        lim = 32'(city_cfg);
        if (lim < 1)
            lim = 1;
        if (lim > MAX_GENES)
            lim = MAX_GENES;
        return lim;
    endfunction

    function automatic void crossover_absorb(input logic [GENE_W-1:0] g1,
                                             input logic [GENE_W-1:0] g2,
                                             input logic [CUT_W-1:0] ca,
                                             input logic [CUT_W-1:0] cb,
                                             input logic fin);
        int unsigned       lim;
        int unsigned       pos;
        int unsigned       n;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       fill;
        logic [GENE_W-1:0] child [MAX_GENES];
        logic [GENE_W-1:0] g;
        child_word_t       w;
        lim = tour_limit();
        pos = load_cnt;
        if (pos >= lim)
            pos = lim - 1;
        if (pos == 0)
        begin
            used_genes = '0;
            seg_lo = 32'((ca <= cb) ? ca : cb);
            seg_hi = 32'((ca <= cb) ? cb : ca);
        end
        p1_mem[pos] = g1;
        p2_mem[pos] = g2;
        if (pos >= seg_lo && pos < seg_hi && gene_valid(g1))
            used_genes[g1 - 1] = 1'b1;
        n = pos + 1;
        load_cnt = n;
        if (!fin && n < lim)
            return;
        lo = (seg_lo < n) ? seg_lo : n;
        hi = (seg_hi < n) ? seg_hi : n;
        for (int k = 0; k < n; k++)
            child[k] = (k >= lo && k < hi) ? p1_mem[k] : '0;
        fill = 0;
        for (int k = 0; k < n; k++)
        begin
            g = p2_mem[k];
            if (gene_valid(g) && used_genes[g - 1])
                continue;
            if (fill >= lo && fill < hi)
                fill = hi;
            if (fill >= n)
                continue;
            child[fill] = g;
            fill++;
        end
        for (int k = 0; k < n; k++)
        begin
            w.gene = child[k];
            w.last = (k + 1 == n);
            child_q.insert(child_q.size(), w);
        end
        load_cnt = 0;
        used_genes = '0;
    endfunction

    task automatic send_word(input logic [GENE_W-1:0] g1, input logic [GENE_W-1:0] g2,
                             input logic [CUT_W-1:0] ca, input logic [CUT_W-1:0] cb,
                             input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        first_parent_gene  = g1;
        second_parent_gene = g2;
        cut_start          = ca;
        cut_end            = cb;
        is_final           = fin;
        push               = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        crossover_absorb(g1, g2, ca, cb, fin);
        @(negedge clk);
    endtask

    task automatic send_pair(input int n, input bit well_formed);
        logic [GENE_W-1:0] t1 [MAX_GENES];
        logic [GENE_W-1:0] t2 [MAX_GENES];
        logic [GENE_W-1:0] tmp;
        logic [CUT_W-1:0]  ca;
        logic [CUT_W-1:0]  cb;
        logic              fin;
        int                j;
        int unsigned       lim;
        lim = tour_limit();
        for (int i = 0; i < n; i++)
        begin
            t1[i] = well_formed ? GENE_W'(i + 1) : GENE_W'($urandom_range(127));
            t2[i] = well_formed ? GENE_W'(i + 1) : GENE_W'($urandom_range(127));
        end
        if (well_formed)
        begin
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                tmp = t1[i]; t1[i] = t1[j]; t1[j] = tmp;
                j = $urandom_range(i);
                tmp = t2[i]; t2[i] = t2[j]; t2[j] = tmp;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == 0 && well_formed)
            begin
                ca = CUT_W'($urandom_range(n));
                cb = CUT_W'($urandom_range(n));
            end
            else
            begin
                ca = CUT_W'($urandom_range(127));
                cb = CUT_W'($urandom_range(127));
            end
            if (i == n - 1)
                fin = (n < lim) ? 1'b1 : 1'($urandom_range(1));
            else
                fin = 1'b0;
            send_word(t1[i], t2[i], ca, cb, fin);
        end
    endtask

    task automatic drain();
        push = 1'b0;
        while (child_q.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic set_city_count(input logic [CFG_W-1:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        city_cfg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = IDLE_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = IDLE_PCT;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = BOTH_PCT;
                recv_stall_pct = BOTH_PCT;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // hold pop low for a long stretch once the main flow asks for it
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            pop = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            pop = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (child_q.size() == 0)
            begin
                $error("unexpected word: child_gene %0d child_last %0d", child_gene, child_last);
                errors++;
            end
            else
            begin
                seen_word = child_q.pop_front();
                if (child_gene !== seen_word.gene)
                begin
                    $error("child_gene: expected %0d, got %0d", seen_word.gene, child_gene);
                    errors++;
                end
                if (child_last !== seen_word.last)
                begin
                    $error("child_last: expected %0d, got %0d", seen_word.last, child_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        child_word_t w;
        int          idx;
        int          items;
        int          n;
        int unsigned lim;
        bit          paused;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        push               = 1'b0;
        first_parent_gene  = '0;
        second_parent_gene = '0;
        cut_start          = '0;
        cut_end            = '0;
        is_final           = 1'b0;
        used_genes         = '0;
        load_cnt           = 0;
        seg_lo             = 0;
        seg_hi             = 0;
        city_cfg           = ocx_pkg::CITY_COUNT_RESET;
        for (int i = 0; i < MAX_GENES; i++)
        begin
            p1_mem[i] = '0;
            p2_mem[i] = '0;
        end
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_city_count(CFG_W'(64));

        for (int r = 0; r < N_DIR; r++)
        begin
            send_word(DIR_ROWS[r].g1, DIR_ROWS[r].g2, DIR_ROWS[r].ca, DIR_ROWS[r].cb,
                      DIR_ROWS[r].fin);
            // overwrite the words just predicted for this pair with the typed ones
            for (int k = 0; k < DIR_ROWS[r].n_typed; k++)
            begin
                idx = child_q.size() - int'(DIR_ROWS[r].n_typed) + k;
                w.gene = (k == 0) ? DIR_ROWS[r].e0 : DIR_ROWS[r].e1;
                w.last = (k == DIR_ROWS[r].n_typed - 1);
                child_q[idx] = w;
            end
        end

        paused = 1'b0;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            set_city_count(CFG_W'(PH_CFG[ph]));
            set_idle(PH_MODE[ph]);
            lim = tour_limit();
            if (ph == PRESSURE_PH)
            begin
                hold_req = 1'b1;
                repeat (3)
                    send_pair((lim < 4) ? lim : 4, 1'b1);
            end
            else
            begin
                items = 0;
                if (ph == LONG_PH)
                begin
                    send_pair(lim, 1'b1);
                    items = PHASE_ITEMS;
                end
                while (items < PHASE_ITEMS)
                begin
                    n = $urandom_range(1, (lim < 8) ? lim : 8);
                    send_pair(n, $urandom_range(99) < 80);
                    items += n;
                    if (ph == PAUSE_PH && !paused && items >= PHASE_ITEMS / 2)
                    begin
                        drain();
                        paused = 1'b1;
                    end
                end
            end
        end

        drain();
        repeat (16)
            @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ocx_pkg.sv
hw/rtl/ocx_fifo.sv
hw/rtl/ocx_store.sv
hw/rtl/ocx_front.sv
hw/rtl/ocx_back.sv
hw/rtl/order_crossover_child_top.sv
hw/rtl/ocx_checker.sv
tb/testbench.sv
